FILE: rtl/core/sbmq_pkg.sv
// Shared types and constants for the shared-buffer multi-queue.
`default_nettype none

package sbmq_pkg;

  localparam int unsigned NUM_QUEUES = 8;
  localparam int unsigned NUM_SLOTS  = 64;

  // slot address, and slot pointer with room for the null code
  localparam int unsigned AW = $clog2(NUM_SLOTS);
  localparam int unsigned PW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  localparam int unsigned DATA_W = 32;

  // output word buffer depth; covers every word in flight
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FW         = $clog2(FIFO_DEPTH);
  localparam int unsigned CW         = $clog2(FIFO_DEPTH + 1);

  typedef logic [PW-1:0] slot_t;

  localparam slot_t NULL_SLOT = PW'(NUM_SLOTS);

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                     mode;
    logic [2:0]                queue_id;
    logic signed [DATA_W-1:0]  item_value;
  } in_word_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  data_out;
    logic                      buffer_full;
    logic                      queue_empty;
  } out_word_t;

  // per-operation status from the queue controller
  typedef struct packed {
    status_e status;
    logic    buffer_full;
    logic    queue_empty;
    logic    deq_ok;
  } exec_res_t;

  // memory requests from the queue controller
  typedef struct packed {
    logic              link_we;
    logic [AW-1:0]     link_waddr;
    slot_t             link_wdata;
    logic [AW-1:0]     link_raddr;
    logic              data_we;
    logic [AW-1:0]     data_waddr;
    logic [DATA_W-1:0] data_wdata;
    logic              data_re;
    logic [AW-1:0]     data_raddr;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/sbmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sbmq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sbmq_link_mem.sv
// Slot link store: RAM plus per-slot valid bits; unwritten slots read as slot+1.
`default_nettype none

module sbmq_link_mem (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   we_i,
  input  wire logic [sbmq_pkg::AW-1:0] waddr_i,
  input  wire sbmq_pkg::slot_t        wdata_i,
  input  wire logic [sbmq_pkg::AW-1:0] raddr_i,
  output sbmq_pkg::slot_t             rdata_o
);

  logic [sbmq_pkg::NUM_SLOTS-1:0] vld_q;
  logic                           rd_vld_q;
  logic [sbmq_pkg::AW-1:0]        rd_addr_q;
  sbmq_pkg::slot_t                ram_rdata;

  sbmq_ram #(
    .WIDTH (sbmq_pkg::PW),
    .DEPTH (sbmq_pkg::NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (1'b1),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= raddr_i;
  end

  // reset image: slot i links to i+1, last slot to null
  assign rdata_o = rd_vld_q ? ram_rdata
                            : sbmq_pkg::slot_t'(rd_addr_q) + sbmq_pkg::slot_t'(1);

endmodule

`default_nettype wire

FILE: rtl/core/sbmq_ctrl.sv
// Queue controller: free list, per-queue head/tail and prefetched next links.
`default_nettype none

module sbmq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               ex_vld_i,
  input  wire sbmq_pkg::in_word_t ex_i,
  input  wire sbmq_pkg::slot_t    link_rdata_i,
  output sbmq_pkg::mem_req_t      mem_o,
  output sbmq_pkg::exec_res_t     res_o
);

  // free list head and its successor
  sbmq_pkg::slot_t fh_q, fh_d;
  sbmq_pkg::slot_t fn_q, fn_d;
  sbmq_pkg::slot_t head_q  [sbmq_pkg::NUM_QUEUES];
  sbmq_pkg::slot_t head_d  [sbmq_pkg::NUM_QUEUES];
  sbmq_pkg::slot_t tail_q  [sbmq_pkg::NUM_QUEUES];
  sbmq_pkg::slot_t tail_d  [sbmq_pkg::NUM_QUEUES];
  // link of each queue's head; meaningful while head != tail
  sbmq_pkg::slot_t hnext_q [sbmq_pkg::NUM_QUEUES];
  sbmq_pkg::slot_t hnext_d [sbmq_pkg::NUM_QUEUES];
  // link read in flight: lands in fn or in hnext of pend_qid
  logic                    pend_fn_q, pend_fn_d;
  logic                    pend_hn_q, pend_hn_d;
  logic [sbmq_pkg::QW-1:0] pend_qid_q, pend_qid_d;

  logic [sbmq_pkg::QW-1:0] q;
  sbmq_pkg::slot_t         head, tail, fn_eff, hn_eff;

  always_comb begin
    q      = ex_i.queue_id[sbmq_pkg::QW-1:0];
    head   = head_q[q];
    tail   = tail_q[q];
    fn_eff = pend_fn_q ? link_rdata_i : fn_q;
    hn_eff = (pend_hn_q && (pend_qid_q == q)) ? link_rdata_i : hnext_q[q];

    fh_d       = fh_q;
    fn_d       = fn_eff;
    head_d     = head_q;
    tail_d     = tail_q;
    hnext_d    = hnext_q;
    if (pend_hn_q) begin
      hnext_d[pend_qid_q] = link_rdata_i;
    end
    pend_fn_d  = 1'b0;
    pend_hn_d  = 1'b0;
    pend_qid_d = pend_qid_q;

    mem_o            = '0;
    mem_o.data_wdata = ex_i.item_value;
    res_o            = '0;
    res_o.status     = sbmq_pkg::ST_OK;

    if (ex_vld_i) begin
      unique case (ex_i.mode)
        sbmq_pkg::MODE_ENQ: begin
          if (fh_q == sbmq_pkg::NULL_SLOT) begin
            res_o.status = sbmq_pkg::ST_FULL;
          end else begin
            fh_d             = fn_eff;
            // fetch the next free link for the new successor
            mem_o.link_raddr = fn_eff[sbmq_pkg::AW-1:0];
            pend_fn_d        = (fn_eff != sbmq_pkg::NULL_SLOT);
            mem_o.data_we    = 1'b1;
            mem_o.data_waddr = fh_q[sbmq_pkg::AW-1:0];
            tail_d[q]        = fh_q;
            if (head == sbmq_pkg::NULL_SLOT) begin
              head_d[q] = fh_q;
            end else begin
              mem_o.link_we    = 1'b1;
              mem_o.link_waddr = tail[sbmq_pkg::AW-1:0];
              mem_o.link_wdata = fh_q;
              if (head == tail) begin
                hnext_d[q] = fh_q;
              end
            end
          end
        end
        sbmq_pkg::MODE_DEQ: begin
          if (head == sbmq_pkg::NULL_SLOT) begin
            res_o.status = sbmq_pkg::ST_EMPTY;
          end else begin
            res_o.deq_ok     = 1'b1;
            mem_o.data_re    = 1'b1;
            mem_o.data_raddr = head[sbmq_pkg::AW-1:0];
            // freed slot goes to the front of the free list
            mem_o.link_we    = 1'b1;
            mem_o.link_waddr = head[sbmq_pkg::AW-1:0];
            mem_o.link_wdata = fh_q;
            fh_d             = head;
            fn_d             = fh_q;
            if (head == tail) begin
              head_d[q] = sbmq_pkg::NULL_SLOT;
              tail_d[q] = sbmq_pkg::NULL_SLOT;
            end else begin
              head_d[q]        = hn_eff;
              mem_o.link_raddr = hn_eff[sbmq_pkg::AW-1:0];
              pend_hn_d        = 1'b1;
              pend_qid_d       = q;
            end
          end
        end
        default: begin
          res_o.status = sbmq_pkg::ST_OK;
        end
      endcase
    end

    res_o.buffer_full = (fh_d == sbmq_pkg::NULL_SLOT);
    res_o.queue_empty = (head_d[q] == sbmq_pkg::NULL_SLOT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q       <= '0;
      fn_q       <= sbmq_pkg::slot_t'(1);
      pend_fn_q  <= 1'b0;
      pend_hn_q  <= 1'b0;
      pend_qid_q <= '0;
      for (int i = 0; i < sbmq_pkg::NUM_QUEUES; i++) begin
        head_q[i]  <= sbmq_pkg::NULL_SLOT;
        tail_q[i]  <= sbmq_pkg::NULL_SLOT;
        hnext_q[i] <= sbmq_pkg::NULL_SLOT;
      end
    end else begin
      fh_q       <= fh_d;
      fn_q       <= fn_d;
      pend_fn_q  <= pend_fn_d;
      pend_hn_q  <= pend_hn_d;
      pend_qid_q <= pend_qid_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      hnext_q    <= hnext_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sbmq_out_fifo.sv
// Output word buffer that decouples the result stage from the receiver.
`default_nettype none

module sbmq_out_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire sbmq_pkg::out_word_t word_i,
  input  wire logic                pop_i,
  output logic                     full_o,
  output logic                     valid_o,
  output sbmq_pkg::out_word_t      word_o
);

  sbmq_pkg::out_word_t     mem_q [sbmq_pkg::FIFO_DEPTH];
  logic [sbmq_pkg::FW-1:0] wptr_q, rptr_q;
  logic [sbmq_pkg::CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + sbmq_pkg::FW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + sbmq_pkg::FW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + sbmq_pkg::CW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - sbmq_pkg::CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= word_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == sbmq_pkg::CW'(sbmq_pkg::FIFO_DEPTH));
  assign word_o  = mem_q[rptr_q];

endmodule

`default_nettype wire

FILE: rtl/core/shared_buffer_multi_queue.sv
// Top level of the shared-buffer multi-queue.
//
// Eight FIFO queues share one 64-slot store, chained by per-slot next links
// with a free list of unused slots. Each input word (in_i) is an enqueue or a
// dequeue on one queue; each produces exactly one output word (out_o) with
// status, dequeued data, buffer-full and queue-empty flags.
// Channels: valid/stall on both sides; a word moves when valid is high and
// stall is low at a rising edge.
// Throughput: one word per cycle while in_stall_o is low. The next free slot and each
// queue's head successor are held prefetched, so the single link RAM read per
// operation lands in time for the following one.
// A word accepted on in_i passes the input register, the controller pass with
// data RAM read and the output buffer before it shows on out_o.
// Stall: a four-word output buffer absorbs the receiver stalling; in_stall_o
// rises only once four words are in flight or waiting.
// Reset (rst_ni low, asynchronous): all queues empty, every slot free, and
// the link store reads as its initial chain through per-slot valid bits;
// no clearing pass, the block accepts words right after reset.
`default_nettype none

module shared_buffer_multi_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire sbmq_pkg::in_word_t  in_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output sbmq_pkg::out_word_t      out_o
);

  // input register
  logic                 in_vld_q;
  sbmq_pkg::in_word_t   in_q;

  // result register (data comes from the data RAM read register)
  logic                 res_vld_q;
  sbmq_pkg::exec_res_t  res_q;

  sbmq_pkg::exec_res_t  ex_res;
  sbmq_pkg::mem_req_t   mem_req;
  sbmq_pkg::slot_t      link_rdata;
  logic [sbmq_pkg::DATA_W-1:0] data_rdata;

  sbmq_pkg::out_word_t  res_word;
  logic                 fifo_full;

  // words accepted and not yet delivered
  logic [sbmq_pkg::CW-1:0] cnt_q;
  logic                    in_acc, out_acc;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign in_stall_o = (cnt_q == sbmq_pkg::CW'(sbmq_pkg::FIFO_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_acc && !out_acc) begin
        cnt_q <= cnt_q + sbmq_pkg::CW'(1);
      end else if (!in_acc && out_acc) begin
        cnt_q <= cnt_q - sbmq_pkg::CW'(1);
      end
      in_vld_q  <= in_acc;
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_i;
    end
    res_q <= ex_res;
  end

  sbmq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ex_vld_i     (in_vld_q),
    .ex_i         (in_q),
    .link_rdata_i (link_rdata),
    .mem_o        (mem_req),
    .res_o        (ex_res)
  );

  sbmq_link_mem u_link (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_req.link_we),
    .waddr_i (mem_req.link_waddr),
    .wdata_i (mem_req.link_wdata),
    .raddr_i (mem_req.link_raddr),
    .rdata_o (link_rdata)
  );

  // slot payloads; only read after being written
  sbmq_ram #(
    .WIDTH (sbmq_pkg::DATA_W),
    .DEPTH (sbmq_pkg::NUM_SLOTS)
  ) u_data (
    .clk_i   (clk_i),
    .we_i    (mem_req.data_we),
    .waddr_i (mem_req.data_waddr),
    .wdata_i (mem_req.data_wdata),
    .re_i    (mem_req.data_re),
    .raddr_i (mem_req.data_raddr),
    .rdata_o (data_rdata)
  );

  always_comb begin
    res_word.status      = res_q.status;
    res_word.buffer_full = res_q.buffer_full;
    res_word.queue_empty = res_q.queue_empty;
    if (res_q.deq_ok) begin
      res_word.data_out = data_rdata;
    end else if (res_q.status == sbmq_pkg::ST_EMPTY) begin
      res_word.data_out = '1;
    end else begin
      res_word.data_out = '0;
    end
  end

  sbmq_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_vld_q),
    .word_i  (res_word),
    .pop_i   (out_acc),
    .full_o  (fifo_full),
    .valid_o (out_valid_o),
    .word_o  (out_o)
  );

  // credit count bounds the buffer, so a result never finds it full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> !fifo_full)
    else $error("output buffer overflow");

  // a refused enqueue only happens with an empty free list
  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.status == sbmq_pkg::ST_FULL) |-> res_q.buffer_full)
    else $error("full status without full buffer");

  // a dequeue on an empty queue leaves it empty
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.status == sbmq_pkg::ST_EMPTY) |-> res_q.queue_empty)
    else $error("empty status without empty queue");

  // every delivered word was counted in
  a_cnt_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != '0))
    else $error("output word with no word in flight");

endmodule

`default_nettype wire
